// File: rtl/sfd_pkg.sv
package sfd_pkg;

   // register field widths
   localparam int DL_W    = 16;
   localparam int FB_W    = 16;
   localparam int MIX_W   = 17;
   localparam int STEPS_W = 12;
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 17;

   // wet fraction carries extra fraction bits
   localparam int WET_SHIFT = 14;
   localparam int WET_W     = 32;
   localparam int DIV_W     = 31;

   localparam logic [FB_W-1:0]  FB_MAX  = 16'd64880;
   localparam logic [MIX_W-1:0] MIX_MAX = 17'd65536;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DELAY_LENGTH  = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FEEDBACK_GAIN = 4'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MIX_TARGET    = 4'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_STEPS    = 4'd3;

   // register reset values
   localparam logic [DL_W-1:0]    DL_RESET    = 16'd11025;
   localparam logic [FB_W-1:0]    FB_RESET    = 16'd19661;
   localparam logic [MIX_W-1:0]   MIX_RESET   = 17'd32768;
   localparam logic [STEPS_W-1:0] STEPS_RESET = 12'd882;

   typedef struct packed {
      logic             done;
      logic [MIX_W-1:0] wet;
   } wet_stat_type;

   typedef struct packed {
      logic mul_en;
      logic sum_en;
      logic wr_en;
   } line_ctl_type;

endpackage

// File: rtl/sfd_div.sv
module sfd_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            start,
   input  logic [sfd_pkg::DIV_W-1:0]       dividend,
   input  logic [sfd_pkg::STEPS_W-1:0]     divisor,
   output logic                            done,
   output logic [sfd_pkg::DIV_W-1:0]       quotient
);

   localparam int CNT_W = $clog2(sfd_pkg::DIV_W);
   localparam int SW    = sfd_pkg::STEPS_W;
   localparam int DW    = sfd_pkg::DIV_W;

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [SW-1:0]     rem_ff, rem_in;
   logic [SW-1:0]     den_ff, den_in;
   logic [DW-1:0]     acc_ff, acc_in;
   logic [SW:0]       trial;
   logic              ge;

   // restoring division, one quotient bit per cycle
   always_comb begin
      trial   = {rem_ff, acc_ff[DW-1]};
      ge      = trial >= {1'b0, den_ff};
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      acc_in  = acc_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(DW - 1);
         rem_in  = '0;
         den_in  = divisor;
         acc_in  = dividend;
      end else if (busy_ff) begin
         rem_in = ge ? SW'(trial - {1'b0, den_ff}) : trial[SW-1:0];
         acc_in = {acc_ff[DW-2:0], ge};
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      acc_ff <= acc_in;
   end

   assign done     = done_ff;
   assign quotient = acc_ff;

endmodule

// File: rtl/sfd_wet.sv
module sfd_wet (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   input  logic [sfd_pkg::MIX_W-1:0]     target,
   input  logic [sfd_pkg::STEPS_W-1:0]   steps,
   output sfd_pkg::wet_stat_type         stat
);

   localparam int WW = sfd_pkg::WET_W;
   localparam int DW = sfd_pkg::DIV_W;

   typedef enum logic {W_IDLE, W_DIV} wet_state_type;

   wet_state_type                  state_ff, state_in;
   logic [sfd_pkg::MIX_W-1:0]      seen_ff, seen_in;
   logic [WW-1:0]                  wet_ff, wet_in;
   logic [WW-1:0]                  inc_ff, inc_in;
   logic [sfd_pkg::STEPS_W-1:0]    rl_ff, rl_in;
   logic [DW-1:0]                  mag_ff, mag_in;
   logic                           neg_ff, neg_in;
   logic                           done_ff, done_in;
   logic                           div_start_ff, div_start_in;

   logic                           div_done;
   logic [DW-1:0]                  quo;
   logic [WW-1:0]                  goal_new, goal_seen, inc_sel, wet_adv;
   logic [sfd_pkg::STEPS_W-1:0]    rl_dec;

   sfd_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start_ff),
      .dividend (mag_ff),
      .divisor  (rl_ff),
      .done     (div_done),
      .quotient (quo)
   );

   always_comb begin
      goal_new  = WW'(target) << sfd_pkg::WET_SHIFT;
      goal_seen = WW'(seen_ff) << sfd_pkg::WET_SHIFT;
      inc_sel   = (state_ff == W_DIV) ? (neg_ff ? WW'(0) - WW'(quo) : WW'(quo)) : inc_ff;
      rl_dec    = rl_ff - 1'b1;
      wet_adv   = (rl_dec == '0) ? goal_seen : wet_ff + inc_sel;

      state_in     = state_ff;
      seen_in      = seen_ff;
      wet_in       = wet_ff;
      inc_in       = inc_ff;
      rl_in        = rl_ff;
      mag_in       = mag_ff;
      neg_in       = neg_ff;
      done_in      = 1'b0;
      div_start_in = 1'b0;

      unique case (state_ff)
         W_IDLE: begin
            if (start) begin
               if (target != seen_ff) begin
                  seen_in = target;
                  if (steps == '0) begin
                     wet_in  = goal_new;
                     rl_in   = '0;
                     done_in = 1'b1;
                  end else begin
                     // ramp count doubles as the divisor while dividing
                     rl_in        = steps;
                     neg_in       = goal_new < wet_ff;
                     mag_in       = (goal_new >= wet_ff) ? DW'(goal_new - wet_ff)
                                                         : DW'(wet_ff - goal_new);
                     div_start_in = 1'b1;
                     state_in     = W_DIV;
                  end
               end else begin
                  if (rl_ff != '0) begin
                     rl_in  = rl_dec;
                     wet_in = wet_adv;
                  end
                  done_in = 1'b1;
               end
            end
         end
         W_DIV: begin
            if (div_done) begin
               inc_in   = inc_sel;
               rl_in    = rl_dec;
               wet_in   = wet_adv;
               done_in  = 1'b1;
               state_in = W_IDLE;
            end
         end
         default: state_in = W_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= W_IDLE;
         seen_ff      <= sfd_pkg::MIX_RESET;
         wet_ff       <= WW'(sfd_pkg::MIX_RESET) << sfd_pkg::WET_SHIFT;
         inc_ff       <= '0;
         rl_ff        <= '0;
         done_ff      <= 1'b0;
         div_start_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seen_ff      <= seen_in;
         wet_ff       <= wet_in;
         inc_ff       <= inc_in;
         rl_ff        <= rl_in;
         done_ff      <= done_in;
         div_start_ff <= div_start_in;
      end
      mag_ff <= mag_in;
      neg_ff <= neg_in;
   end

   assign stat.done = done_ff;
   assign stat.wet  = wet_ff[sfd_pkg::WET_SHIFT+sfd_pkg::MIX_W-1:sfd_pkg::WET_SHIFT];

endmodule

// File: rtl/sfd_line.sv
module sfd_line #(
   parameter int LINE_DEPTH  = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                               clock,
   input  sfd_pkg::line_ctl_type              ctl,
   input  logic signed [SAMPLE_BITS-1:0]      x,
   input  logic [$clog2(LINE_DEPTH)-1:0]      rd_addr,
   input  logic                               rd_live,
   input  logic [$clog2(LINE_DEPTH)-1:0]      wr_addr,
   input  logic [sfd_pkg::MIX_W-1:0]          wet,
   input  logic [sfd_pkg::FB_W-1:0]           fb,
   output logic signed [SAMPLE_BITS-1:0]      y
);

   localparam int SB = SAMPLE_BITS;
   localparam int PW = SB + 18;
   localparam int FW = SB + 17;
   localparam int SW = SB + 19;
   localparam logic signed [SW-1:0] HI  = SW'((64'sd1 <<< (SB - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] LO  = -HI - SW'(1);
   localparam logic signed [SW-1:0] RND = SW'(32768);
   localparam logic signed [FW-1:0] FRND = FW'(32768);

   logic signed [SB-1:0]  mem [LINE_DEPTH];
   logic signed [SB-1:0]  q_ff;
   logic                  live_ff;
   logic signed [PW-1:0]  p_dry_ff, p_wet_ff;
   logic signed [FW-1:0]  p_fb_ff;
   logic signed [SB-1:0]  y_ff;
   logic signed [SB:0]    fbr_ff;

   logic [sfd_pkg::MIX_W-1:0] dry;
   logic signed [17:0]    dry_s, wet_s;
   logic signed [16:0]    fb_s;
   logic signed [SB-1:0]  d;
   logic signed [SW-1:0]  acc, acc_sh, fsum;
   logic signed [FW-1:0]  fadd, fadd_sh;
   logic signed [SB-1:0]  y_in, st_in;

   always_comb begin
      dry     = sfd_pkg::MIX_W'(sfd_pkg::MIX_MAX - wet);
      dry_s   = signed'({1'b0, dry});
      wet_s   = signed'({1'b0, wet});
      fb_s    = signed'({1'b0, fb});
      // never-written entries read as zero
      d       = live_ff ? q_ff : '0;
      acc     = SW'(p_dry_ff) + SW'(p_wet_ff) + RND;
      acc_sh  = acc >>> 16;
      y_in    = (acc_sh > HI) ? HI[SB-1:0] : (acc_sh < LO) ? LO[SB-1:0] : acc_sh[SB-1:0];
      fadd    = p_fb_ff + FRND;
      fadd_sh = fadd >>> 16;
      fsum    = SW'(y_ff) + SW'(fbr_ff);
      st_in   = (fsum > HI) ? HI[SB-1:0] : (fsum < LO) ? LO[SB-1:0] : fsum[SB-1:0];
   end

   always_ff @(posedge clock) begin
      q_ff    <= mem[rd_addr];
      live_ff <= rd_live;
      if (ctl.wr_en) begin
         mem[wr_addr] <= st_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.mul_en) begin
         p_dry_ff <= PW'(x) * PW'(dry_s);
         p_wet_ff <= PW'(d) * PW'(wet_s);
         p_fb_ff  <= FW'(d) * FW'(fb_s);
      end
      if (ctl.sum_en) begin
         y_ff   <= y_in;
         fbr_ff <= fadd_sh[SB:0];
      end
   end

   assign y = y_ff;

endmodule

// File: rtl/stereo_feedback_delay_top.sv
// stereo echo with feedback and a smoothed wet/dry mix
//
// req channel: one stereo frame per beat (req_left_in, req_right_in), valid/ready.
// rsp channel: one mixed stereo frame per beat (rsp_left_out, rsp_right_out).
// csr port: write-only, csr_wr_en with csr_index and csr_wr_data, no wait states;
// index 0 delay_length, 1 feedback_gain, 2 mix_target, 3 ramp_steps.
//
// from accept to result a frame with the mix target unchanged passes these steps:
// wet update and line read, multiply, round and saturate, write back.
// the next frame is accepted in the cycle its predecessor's result is registered,
// so a new frame is taken only while idle or as its predecessor is written back.
// the first frame after a new mix target with a nonzero ramp also waits in the wet
// step for a serial divider that makes the per-frame ramp increment, one bit per cycle.
//
// reset restores the register defaults and empties both delay lines; a fill
// flag and the write pointer track which entries were written, so there is no clearing pass.
// when the receiver stalls the result stays in the output register and the
// frame behind it waits in the write-back step until the register is free.
module stereo_feedback_delay_top #(
   parameter int LINE_DEPTH  = 65536,
   parameter int SAMPLE_BITS = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [SAMPLE_BITS-1:0]         req_left_in,
   input  logic signed [SAMPLE_BITS-1:0]         req_right_in,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic signed [SAMPLE_BITS-1:0]         rsp_left_out,
   output logic signed [SAMPLE_BITS-1:0]         rsp_right_out,
   input  logic                                  csr_wr_en,
   input  logic [sfd_pkg::CSR_IDX_W-1:0]         csr_index,
   input  logic [sfd_pkg::CSR_DATA_W-1:0]        csr_wr_data
);

   localparam int AW = $clog2(LINE_DEPTH);
   // wide enough for the delay register and the line depth itself
   localparam int LW = ((AW > sfd_pkg::DL_W) ? AW : sfd_pkg::DL_W) + 1;

   typedef enum logic [2:0] {S_IDLE, S_WET, S_MUL, S_SUM, S_OUT} state_type;

   state_type                     state_ff, state_in;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [AW-1:0]                 wp_ff, wp_in;
   logic                          filled_ff, filled_in;

   // configuration registers
   logic [sfd_pkg::DL_W-1:0]      delay_length_ff;
   logic [sfd_pkg::FB_W-1:0]      feedback_gain_ff;
   logic [sfd_pkg::MIX_W-1:0]     mix_target_ff;
   logic [sfd_pkg::STEPS_W-1:0]   ramp_steps_ff;

   // payload registers
   logic signed [SAMPLE_BITS-1:0] left_x_ff, right_x_ff;
   logic signed [SAMPLE_BITS-1:0] left_out_ff, right_out_ff;

   logic                          accept, fin;
   logic [LW-1:0]                 dl_raw, dl_c, wp_ext, rd_ext;
   logic [AW-1:0]                 rd_addr;
   logic                          rd_live;
   logic [sfd_pkg::FB_W-1:0]      fb_c;
   logic [sfd_pkg::MIX_W-1:0]     mix_c;
   logic signed [SAMPLE_BITS-1:0] left_y, right_y;
   sfd_pkg::wet_stat_type         wet_stat;
   sfd_pkg::line_ctl_type         line_ctl;

   // handshakes: write-back waits for a free output register, nothing taken in reset
   assign fin       = (state_ff == S_OUT) && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !reset && ((state_ff == S_IDLE) || fin);
   assign accept    = req_valid && req_ready;

   // register clamps
   assign fb_c  = (feedback_gain_ff > sfd_pkg::FB_MAX) ? sfd_pkg::FB_MAX : feedback_gain_ff;
   assign mix_c = (mix_target_ff > sfd_pkg::MIX_MAX) ? sfd_pkg::MIX_MAX : mix_target_ff;

   // read address, delay held within one to depth minus one
   always_comb begin
      dl_raw = LW'(delay_length_ff);
      if (dl_raw == '0) begin
         dl_c = LW'(1);
      end else if (dl_raw > LW'(LINE_DEPTH - 1)) begin
         dl_c = LW'(LINE_DEPTH - 1);
      end else begin
         dl_c = dl_raw;
      end
      wp_ext  = LW'(wp_ff);
      rd_ext  = (wp_ext >= dl_c) ? wp_ext - dl_c : wp_ext + LW'(LINE_DEPTH) - dl_c;
      rd_addr = rd_ext[AW-1:0];
      // before the first wrap only entries below the write pointer hold data
      rd_live = filled_ff || (wp_ext >= dl_c);
   end

   assign line_ctl.mul_en = (state_ff == S_MUL);
   assign line_ctl.sum_en = (state_ff == S_SUM);
   assign line_ctl.wr_en  = fin;

   sfd_wet u_wet (
      .clock  (clock),
      .reset  (reset),
      .start  (accept),
      .target (mix_c),
      .steps  (ramp_steps_ff),
      .stat   (wet_stat)
   );

   sfd_line #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_left (
      .clock   (clock),
      .ctl     (line_ctl),
      .x       (left_x_ff),
      .rd_addr (rd_addr),
      .rd_live (rd_live),
      .wr_addr (wp_ff),
      .wet     (wet_stat.wet),
      .fb      (fb_c),
      .y       (left_y)
   );

   sfd_line #(
      .LINE_DEPTH  (LINE_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_right (
      .clock   (clock),
      .ctl     (line_ctl),
      .x       (right_x_ff),
      .rd_addr (rd_addr),
      .rd_live (rd_live),
      .wr_addr (wp_ff),
      .wet     (wet_stat.wet),
      .fb      (fb_c),
      .y       (right_y)
   );

   // frame sequencer
   always_comb begin
      state_in     = state_ff;
      wp_in        = wp_ff;
      filled_in    = filled_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: if (accept) state_in = S_WET;
         S_WET:  if (wet_stat.done) state_in = S_MUL;
         S_MUL:  state_in = S_SUM;
         S_SUM:  state_in = S_OUT;
         S_OUT: begin
            if (fin) begin
               state_in = accept ? S_WET : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      if (fin) begin
         rsp_valid_in = 1'b1;
         if (wp_ff == AW'(LINE_DEPTH - 1)) begin
            wp_in     = '0;
            filled_in = 1'b1;
         end else begin
            wp_in = wp_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         wp_ff        <= '0;
         filled_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         wp_ff        <= wp_in;
         filled_ff    <= filled_in;
      end
      if (fin) begin
         left_out_ff  <= left_y;
         right_out_ff <= right_y;
      end
      if (accept) begin
         left_x_ff  <= req_left_in;
         right_x_ff <= req_right_in;
      end
   end

   // register writes, unknown indexes dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         delay_length_ff  <= sfd_pkg::DL_RESET;
         feedback_gain_ff <= sfd_pkg::FB_RESET;
         mix_target_ff    <= sfd_pkg::MIX_RESET;
         ramp_steps_ff    <= sfd_pkg::STEPS_RESET;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            sfd_pkg::CSR_DELAY_LENGTH:  delay_length_ff  <= csr_wr_data[sfd_pkg::DL_W-1:0];
            sfd_pkg::CSR_FEEDBACK_GAIN: feedback_gain_ff <= csr_wr_data[sfd_pkg::FB_W-1:0];
            sfd_pkg::CSR_MIX_TARGET:    mix_target_ff    <= csr_wr_data[sfd_pkg::MIX_W-1:0];
            sfd_pkg::CSR_RAMP_STEPS:    ramp_steps_ff    <= csr_wr_data[sfd_pkg::STEPS_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_left_out  = left_out_ff;
   assign rsp_right_out = right_out_ff;

endmodule
